// File: src/srsw_pkg.sv
`timescale 1ns / 1ps
package srsw_pkg;

  localparam int SEQ_SPACE_DEF   = 256;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [7:0]  WINDOW_RST   = 8'd8;
  localparam logic [3:0]  SEQ_BITS_RST = 4'd8;
  localparam logic [15:0] TOTAL_RST    = 16'd1000;
  localparam logic [6:0]  BUFFER_RST   = 7'd64;
  localparam logic [31:0] TIMEOUT_RST  = 32'd100000;
  localparam logic [15:0] ACK_WARM     = 16'd10;

  localparam int DIV_W  = 57;
  localparam int DVS_W  = 17;
  localparam int MUL_W  = 56;
  localparam int MEAN_W = 40;

  typedef enum logic [2:0] {
    CFG_WINDOW_LIMIT,
    CFG_SEQ_BITS,
    CFG_TOTAL_PACKETS,
    CFG_BUFFER_LIMIT,
    CFG_INITIAL_TIMEOUT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_NEW,
    OP_ACK,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_SENT,
    K_RESENT,
    K_ACKED,
    K_QUEUED,
    K_DROPPED,
    K_STRAY
  } kind_t;

  typedef enum logic [4:0] {
    U_IDLE,
    U_TSTART,
    U_TQD,
    U_TED,
    U_SCAN,
    U_SFIN,
    U_NCHK,
    U_DIV,
    U_NWR,
    U_ACHK,
    U_AMS,
    U_AMUL,
    U_ADIVS,
    U_AUPD,
    U_ASRCH,
    U_ASRCHD,
    U_ASHR,
    U_ASHW,
    U_AFIN,
    U_EMIT
  } uop_t;

  typedef struct packed {
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic tick_send;
    logic ack_hit;
    logic new_drop;
    logic mul_done;
    logic div_done;
    logic scan_end;
    logic srch_end;
    logic srch_hit;
    logic shift_end;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [31:0] tm;
    logic [15:0] len;
    logic [7:0]  att;
  } ent_t;

  typedef struct packed {
    logic [7:0]  seq;
    logic [15:0] len;
  } qent_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// File: src/srsw_div.sv
`timescale 1ns / 1ps
module srsw_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [srsw_pkg::DIV_W-1:0] dividend,
  input  logic [srsw_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [srsw_pkg::DIV_W-1:0] quot,
  output logic [srsw_pkg::DVS_W-1:0] rem
);
  import srsw_pkg::*;

  localparam int CNTW = $clog2(DIV_W + 1);

  logic             busy_r;
  logic [CNTW-1:0]  cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] d_r;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[DIV_W-1]};
    ge      = trial >= {1'b0, d_r};
    rem_nxt = ge ? DVS_W'(trial - {1'b0, d_r}) : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNTW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
      cnt_r <= CNTW'(DIV_W);
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  assign done = !busy_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// File: src/srsw_ctrl.sv
`timescale 1ns / 1ps
module srsw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_op,
  input  srsw_pkg::sts_t  sts,
  output logic            in_ready,
  output srsw_pkg::cmd_t  cmd
);
  import srsw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TSTART,
    S_TQD,
    S_TED,
    S_SCAN,
    S_SFIN,
    S_NCHK,
    S_NDIV,
    S_NWR,
    S_ACHK,
    S_AMS,
    S_AMUL,
    S_ADIVS,
    S_ADIV,
    S_AUPD,
    S_ASRCH,
    S_ASRCHD,
    S_ASHR,
    S_ASHW,
    S_AFIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_op))
            OP_TICK: state_nxt = S_TSTART;
            OP_NEW:  state_nxt = S_NCHK;
            OP_ACK:  state_nxt = S_ACHK;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_TSTART: state_nxt = sts.tick_send ? S_TQD : S_SCAN;
      S_TQD:    state_nxt = S_TED;
      S_TED:    state_nxt = S_EMIT;
      S_SCAN:   state_nxt = sts.scan_end ? S_SFIN : S_SCAN;
      S_SFIN:   state_nxt = S_EMIT;
      S_NCHK:   state_nxt = sts.new_drop ? S_EMIT : S_NDIV;
      S_NDIV:   state_nxt = sts.div_done ? S_NWR : S_NDIV;
      S_NWR:    state_nxt = S_EMIT;
      S_ACHK:   state_nxt = sts.ack_hit ? S_AMS : S_EMIT;
      S_AMS:    state_nxt = S_AMUL;
      S_AMUL:   state_nxt = sts.mul_done ? S_ADIVS : S_AMUL;
      S_ADIVS:  state_nxt = S_ADIV;
      S_ADIV:   state_nxt = sts.div_done ? S_AUPD : S_ADIV;
      S_AUPD:   state_nxt = S_ASRCH;
      S_ASRCH:  state_nxt = sts.srch_end ? S_AFIN : S_ASRCHD;
      S_ASRCHD: state_nxt = sts.srch_hit ? S_ASHR : S_ASRCH;
      S_ASHR:   state_nxt = sts.shift_end ? S_AFIN : S_ASHW;
      S_ASHW:   state_nxt = S_ASHR;
      S_AFIN:   state_nxt = S_EMIT;
      S_EMIT:   state_nxt = sts.out_free ? S_IDLE : S_EMIT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:   cmd.uop = U_IDLE;
      S_TSTART: cmd.uop = U_TSTART;
      S_TQD:    cmd.uop = U_TQD;
      S_TED:    cmd.uop = U_TED;
      S_SCAN:   cmd.uop = U_SCAN;
      S_SFIN:   cmd.uop = U_SFIN;
      S_NCHK:   cmd.uop = U_NCHK;
      S_NDIV:   cmd.uop = U_DIV;
      S_NWR:    cmd.uop = U_NWR;
      S_ACHK:   cmd.uop = U_ACHK;
      S_AMS:    cmd.uop = U_AMS;
      S_AMUL:   cmd.uop = U_AMUL;
      S_ADIVS:  cmd.uop = U_ADIVS;
      S_ADIV:   cmd.uop = U_DIV;
      S_AUPD:   cmd.uop = U_AUPD;
      S_ASRCH:  cmd.uop = U_ASRCH;
      S_ASRCHD: cmd.uop = U_ASRCHD;
      S_ASHR:   cmd.uop = U_ASHR;
      S_ASHW:   cmd.uop = U_ASHW;
      S_AFIN:   cmd.uop = U_AFIN;
      S_EMIT:   cmd.uop = U_EMIT;
      default:  cmd.uop = U_IDLE;
    endcase
  end

  assign in_ready = in_ready_r;

endmodule

// File: src/srsw_dp.sv
`timescale 1ns / 1ps
module srsw_dp #(
  parameter int SEQ_SPACE   = srsw_pkg::SEQ_SPACE_DEF,
  parameter int QUEUE_DEPTH = srsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  srsw_pkg::cmd_t cmd,
  output srsw_pkg::sts_t sts,
  input  logic           in_valid,
  input  logic [7:0]     in_ack_seq,
  input  logic [15:0]    in_pkt_length,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_kind,
  output logic [7:0]     out_seq,
  output logic [15:0]    out_length,
  output logic [7:0]     out_attempts,
  output logic [31:0]    out_rtt_ticks,
  output logic [31:0]    out_attempts_total,
  output logic           out_done_res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_idx,
  input  logic [31:0]    cfg_data
);
  import srsw_pkg::*;

  localparam int SW  = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int SCW = $clog2(SEQ_SPACE + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int BW  = (CW > 7) ? CW : 7;

  // configuration
  logic [7:0]  wl_r;
  logic [3:0]  sb_r;
  logic [15:0] tp_r;
  logic [6:0]  bl_r;
  logic [31:0] it_r;

  // sender state
  logic [31:0]          now_r;
  logic [CW-1:0]        fill_r;
  logic [CW-1:0]        nts_r;
  logic [7:0]           out_cnt_r;
  logic [15:0]          gen_r;
  logic [15:0]          acked_r;
  logic [31:0]          sum_r;
  logic [MEAN_W-1:0]    mean_r;
  logic [SEQ_SPACE-1:0] vld_r;
  logic                 out_valid_r;

  // working registers
  logic [7:0]    ack_r;
  logic [15:0]   len_r;
  logic [SW-1:0] s_r;
  logic [15:0]   qlen_r;
  logic [31:0]   rtt_r;
  logic [7:0]    att_r;
  logic [SCW-1:0] idx_r;
  logic           pv_r;
  logic [SW-1:0]  pidx_r;
  logic           found_r;
  logic [SW-1:0]  best_r;
  logic [31:0]    best_age_r;
  logic [7:0]     best_att_r;
  logic [15:0]    best_len_r;
  logic [CW-1:0]  i_r;
  logic [CW-1:0]  j_r;
  logic [MUL_W-1:0] mul_a_r;
  logic [15:0]      mul_b_r;
  logic [MUL_W-1:0] mul_acc_r;
  logic [4:0]       mul_cnt_r;

  kind_t       res_kind_r;
  logic [7:0]  res_seq_r;
  logic [15:0] res_len_r;
  logic [7:0]  res_att_r;
  logic [31:0] res_rtt_r;
  logic [31:0] res_tot_r;

  kind_t       out_kind_r;
  logic [7:0]  out_seq_r;
  logic [15:0] out_len_r;
  logic [7:0]  out_att_r;
  logic [31:0] out_rtt_r;
  logic [31:0] out_tot_r;
  logic        out_done_r;

  // memories
  ent_t  ent_mem [SEQ_SPACE];
  ent_t  ent_rd_r;
  logic [SW-1:0] ent_raddr;
  logic          ent_we;
  logic [SW-1:0] ent_waddr;
  ent_t          ent_wdata;

  qent_t q_mem [QUEUE_DEPTH];
  qent_t q_rd_r;
  logic [QW-1:0] q_raddr;
  logic          q_we;
  logic [QW-1:0] q_waddr;
  qent_t         q_wdata;

  // divider
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;

  // combinational helpers
  logic [3:0]    sb1;
  logic [8:0]    cap9;
  logic [8:0]    w9;
  logic [7:0]    win;
  logic [6:0]    bl1;
  logic [BW-1:0] eff_buf;
  logic          full;
  logic          in_range;
  logic [31:0]   ent_age;
  logic [31:0]   age_sel;
  logic          tmo;
  logic [CW-1:0] lim;
  logic [CW:0]   jp1;
  logic [32:0]   sum33;
  logic [31:0]   sum_nxt;
  logic          out_free;
  logic [7:0]    ent_att_inc;

  always_comb begin
    sb1  = (sb_r == 4'd0) ? 4'd1 : sb_r;
    cap9 = (sb1 >= 4'd8) ? 9'd255 : 9'((9'd1 << sb1) - 9'd1);
    w9   = {1'b0, wl_r};
    if (w9 > cap9) begin
      w9 = cap9;
    end
    if (w9 > 9'(SEQ_SPACE - 1)) begin
      w9 = 9'(SEQ_SPACE - 1);
    end
    if (w9 == 9'd0) begin
      w9 = 9'd1;
    end
    win = w9[7:0];
  end

  always_comb begin
    bl1      = (bl_r == 7'd0) ? 7'd1 : bl_r;
    eff_buf  = (BW'(bl1) > BW'(QUEUE_DEPTH)) ? BW'(QUEUE_DEPTH) : BW'(bl1);
    full     = BW'(fill_r) >= eff_buf;
    in_range = {1'b0, ack_r} < 9'(SEQ_SPACE);
    ent_age  = now_r - ent_rd_r.tm;
    age_sel  = (cmd.uop == U_TED) ? ent_age : best_age_r;
    if (acked_r > ACK_WARM) begin
      tmo = {1'b0, age_sel, 8'b0} >= {mean_r, 1'b0};
    end else begin
      tmo = age_sel >= it_r;
    end
    lim         = (nts_r < fill_r) ? nts_r : fill_r;
    jp1         = {1'b0, j_r} + (CW+1)'(1);
    sum33       = {1'b0, sum_r} + 33'(att_r);
    sum_nxt     = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
    out_free    = !out_valid_r || out_ready;
    ent_att_inc = sat_inc8(ent_rd_r.att);
  end

  always_comb begin
    sts.tick_send = (out_cnt_r < win) && (nts_r < fill_r);
    sts.ack_hit   = in_range && vld_r[s_r];
    sts.new_drop  = (gen_r >= tp_r) || full;
    sts.mul_done  = (mul_cnt_r == 5'd0);
    sts.div_done  = div_done;
    sts.scan_end  = (idx_r == SCW'(SEQ_SPACE)) && !pv_r;
    sts.srch_end  = (i_r >= lim);
    sts.srch_hit  = (q_rd_r.seq == 8'(s_r));
    sts.shift_end = (jp1 >= {1'b0, fill_r});
    sts.out_free  = out_free;
  end

  // memory ports
  always_comb begin
    ent_raddr = s_r;
    ent_we    = 1'b0;
    ent_waddr = s_r;
    ent_wdata = '{tm: now_r, len: qlen_r, att: 8'd1};
    q_raddr   = nts_r[QW-1:0];
    q_we      = 1'b0;
    q_waddr   = fill_r[QW-1:0];
    q_wdata   = '{seq: 8'(div_rem), len: len_r};
    case (cmd.uop)
      U_TQD:  ent_raddr = q_rd_r.seq[SW-1:0];
      U_SCAN: ent_raddr = idx_r[SW-1:0];
      U_TED: begin
        if (vld_r[s_r]) begin
          ent_we    = tmo;
          ent_wdata = '{tm: now_r, len: ent_rd_r.len, att: ent_att_inc};
        end else begin
          ent_we = 1'b1;
        end
      end
      U_SFIN: begin
        ent_we    = found_r && tmo;
        ent_waddr = best_r;
        ent_wdata = '{tm: now_r, len: best_len_r, att: sat_inc8(best_att_r)};
      end
      U_NWR:   q_we = 1'b1;
      U_ASRCH: q_raddr = i_r[QW-1:0];
      U_ASHR:  q_raddr = jp1[QW-1:0];
      U_ASHW: begin
        q_we    = 1'b1;
        q_waddr = j_r[QW-1:0];
        q_wdata = q_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_r <= q_mem[q_raddr];
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(gen_r);
    div_divisor  = DVS_W'(win);
    case (cmd.uop)
      U_NCHK: div_start = !sts.new_drop;
      U_ADIVS: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(mul_acc_r) + DIV_W'({rtt_r, 8'b0});
        div_divisor  = DVS_W'(acked_r) + DVS_W'(1);
      end
      default: ;
    endcase
  end

  srsw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // sender state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= WINDOW_RST;
      sb_r        <= SEQ_BITS_RST;
      tp_r        <= TOTAL_RST;
      bl_r        <= BUFFER_RST;
      it_r        <= TIMEOUT_RST;
      now_r       <= '0;
      fill_r      <= '0;
      nts_r       <= '0;
      out_cnt_r   <= '0;
      gen_r       <= '0;
      acked_r     <= '0;
      sum_r       <= '0;
      mean_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_WINDOW_LIMIT:    wl_r <= cfg_data[7:0];
          CFG_SEQ_BITS:        sb_r <= cfg_data[3:0];
          CFG_TOTAL_PACKETS:   tp_r <= cfg_data[15:0];
          CFG_BUFFER_LIMIT:    bl_r <= cfg_data[6:0];
          CFG_INITIAL_TIMEOUT: it_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.uop == U_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.uop)
        U_TSTART: now_r <= now_r + 32'd1;
        U_TED: begin
          if (!vld_r[s_r]) begin
            vld_r[s_r] <= 1'b1;
            nts_r      <= nts_r + CW'(1);
            out_cnt_r  <= out_cnt_r + 8'd1;
          end
        end
        U_NWR: begin
          fill_r <= fill_r + CW'(1);
          gen_r  <= gen_r + 16'd1;
        end
        U_AUPD: begin
          mean_r <= div_quot[MEAN_W-1:0];
          sum_r  <= sum_nxt;
          if (acked_r != 16'hFFFF) begin
            acked_r <= acked_r + 16'd1;
          end
        end
        U_ASHR: begin
          if (sts.shift_end) begin
            fill_r <= fill_r - CW'(1);
            nts_r  <= nts_r - CW'(1);
          end
        end
        U_AFIN: begin
          vld_r[s_r] <= 1'b0;
          if (out_cnt_r != 8'd0) begin
            out_cnt_r <= out_cnt_r - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    case (cmd.uop)
      U_IDLE: begin
        if (in_valid) begin
          ack_r      <= in_ack_seq;
          len_r      <= in_pkt_length;
          s_r        <= in_ack_seq[SW-1:0];
          res_kind_r <= K_NONE;
          res_seq_r  <= '0;
          res_len_r  <= '0;
          res_att_r  <= '0;
          res_rtt_r  <= '0;
          res_tot_r  <= '0;
        end
      end
      U_TSTART: begin
        idx_r   <= '0;
        pv_r    <= 1'b0;
        found_r <= 1'b0;
      end
      U_TQD: begin
        s_r    <= q_rd_r.seq[SW-1:0];
        qlen_r <= q_rd_r.len;
      end
      U_TED: begin
        if (vld_r[s_r]) begin
          if (tmo) begin
            res_kind_r <= K_RESENT;
            res_seq_r  <= 8'(s_r);
            res_len_r  <= ent_rd_r.len;
            res_att_r  <= ent_att_inc;
          end
        end else begin
          res_kind_r <= K_SENT;
          res_seq_r  <= 8'(s_r);
          res_len_r  <= qlen_r;
          res_att_r  <= 8'd1;
        end
      end
      U_SCAN: begin
        if (pv_r && vld_r[pidx_r] && (!found_r || ent_age > best_age_r)) begin
          found_r    <= 1'b1;
          best_r     <= pidx_r;
          best_age_r <= ent_age;
          best_att_r <= ent_rd_r.att;
          best_len_r <= ent_rd_r.len;
        end
        if (idx_r != SCW'(SEQ_SPACE)) begin
          pv_r   <= 1'b1;
          pidx_r <= idx_r[SW-1:0];
          idx_r  <= idx_r + SCW'(1);
        end else begin
          pv_r <= 1'b0;
        end
      end
      U_SFIN: begin
        if (found_r && tmo) begin
          res_kind_r <= K_RESENT;
          res_seq_r  <= 8'(best_r);
          res_len_r  <= best_len_r;
          res_att_r  <= sat_inc8(best_att_r);
        end
      end
      U_NCHK: begin
        if (sts.new_drop) begin
          res_kind_r <= K_DROPPED;
        end
      end
      U_NWR: begin
        res_kind_r <= K_QUEUED;
        res_seq_r  <= 8'(div_rem);
      end
      U_ACHK: begin
        if (!sts.ack_hit) begin
          res_kind_r <= K_STRAY;
          res_seq_r  <= ack_r;
        end
      end
      U_AMS: begin
        rtt_r     <= ent_age;
        att_r     <= ent_rd_r.att;
        mul_a_r   <= MUL_W'(mean_r);
        mul_b_r   <= acked_r;
        mul_acc_r <= '0;
        mul_cnt_r <= 5'd16;
      end
      U_AMUL: begin
        if (mul_cnt_r != 5'd0) begin
          if (mul_b_r[0]) begin
            mul_acc_r <= mul_acc_r + mul_a_r;
          end
          mul_a_r   <= mul_a_r << 1;
          mul_b_r   <= mul_b_r >> 1;
          mul_cnt_r <= mul_cnt_r - 5'd1;
        end
      end
      U_AUPD: begin
        res_kind_r <= K_ACKED;
        res_seq_r  <= 8'(s_r);
        res_att_r  <= att_r;
        res_rtt_r  <= rtt_r;
        res_tot_r  <= sum_nxt;
        i_r        <= '0;
      end
      U_ASRCHD: begin
        if (sts.srch_hit) begin
          j_r <= i_r;
        end else begin
          i_r <= i_r + CW'(1);
        end
      end
      U_ASHW: j_r <= j_r + CW'(1);
      U_EMIT: begin
        if (out_free) begin
          out_kind_r <= res_kind_r;
          out_seq_r  <= res_seq_r;
          out_len_r  <= res_len_r;
          out_att_r  <= res_att_r;
          out_rtt_r  <= res_rtt_r;
          out_tot_r  <= res_tot_r;
          out_done_r <= (acked_r >= tp_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_seq            = out_seq_r;
  assign out_length         = out_len_r;
  assign out_attempts       = out_att_r;
  assign out_rtt_ticks      = out_rtt_r;
  assign out_attempts_total = out_tot_r;
  assign out_done_res       = out_done_r;

endmodule

// File: src/selective_repeat_sender_window.sv
`timescale 1ns / 1ps
// Selective-repeat ARQ sender: takes tick, new-packet, acknowledgement and no-op words one
// at a time and returns one result word for each. A new packet waits on the bit-serial
// divider that forms the sequence number. A tick either sends from the queue or scans the
// per-sequence timer memory one entry a cycle. An acknowledgement runs a 16-step shift-add
// multiply and a 57-step divide for the mean RTT, then searches the queue and moves each
// later entry down during buffer compaction. Each result then waits in an output register
// while the next word is taken. No clearing pass is needed after reset.
module selective_repeat_sender_window #(
  parameter int SEQ_SPACE   = srsw_pkg::SEQ_SPACE_DEF,
  parameter int QUEUE_DEPTH = srsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_ack_seq,
  input  logic [15:0] in_pkt_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_seq,
  output logic [15:0] out_length,
  output logic [7:0]  out_attempts,
  output logic [31:0] out_rtt_ticks,
  output logic [31:0] out_attempts_total,
  output logic        out_done_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import srsw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  srsw_dp #(
    .SEQ_SPACE   (SEQ_SPACE),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_valid           (in_valid),
    .in_ack_seq         (in_ack_seq),
    .in_pkt_length      (in_pkt_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_seq            (out_seq),
    .out_length         (out_length),
    .out_attempts       (out_attempts),
    .out_rtt_ticks      (out_rtt_ticks),
    .out_attempts_total (out_attempts_total),
    .out_done_res       (out_done_res),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_data           (cfg_data)
  );

endmodule

// File: src/srsw_chk.sv
`timescale 1ns / 1ps
module srsw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_seq,
  input logic [15:0] out_length,
  input logic [31:0] out_rtt_ticks,
  input logic [31:0] out_attempts_total
);
  import srsw_pkg::*;

  // result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_seq)))
    else $error("result word dropped or changed while stalled");

  // one word in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in work");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_DROPPED) |-> (out_seq == 8'd0 && out_length == 16'd0))
    else $error("dropped result carries payload");

  a_ack_only_rtt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != K_ACKED) |-> (out_rtt_ticks == 32'd0 && out_attempts_total == 32'd0))
    else $error("rtt reported outside an acknowledgement");

endmodule

bind selective_repeat_sender_window srsw_chk u_srsw_chk (.*);

// File: test/selective_repeat_sender_window_tb.sv
`timescale 1ns / 1ps
module selective_repeat_sender_window_tb;
  import srsw_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  seq;
    logic [15:0] length;
    logic [7:0]  attempts;
    logic [31:0] rtt_ticks;
    logic [31:0] attempts_total;
    logic        done_res;
  } arq_res_t;

  class arq_scoreboard;
    logic [7:0]  window_limit;
    logic [3:0]  seq_bits;
    logic [15:0] total_packets;
    logic [6:0]  buffer_limit;
    logic [31:0] initial_timeout;
    logic [31:0] now;
    logic [31:0] sent_time [256];
    logic [7:0]  attempt_count [256];
    logic [15:0] sent_length [256];
    logic [7:0]  queue_seq [64];
    logic [15:0] queue_length [64];
    int unsigned queue_fill, next_to_send, outstanding;
    int unsigned generated, acked;
    logic [31:0] attempt_sum;
    logic [63:0] rtt_mean;
    arq_res_t    pending_results [$];
    int          mismatches;

    function void clear();
      window_limit = WINDOW_RST;
      seq_bits = SEQ_BITS_RST;
      total_packets = TOTAL_RST;
      buffer_limit = BUFFER_RST;
      initial_timeout = TIMEOUT_RST;
      now = 0;
      foreach (attempt_count[i]) begin
        attempt_count[i] = 0;
        sent_time[i] = 0;
        sent_length[i] = 0;
      end
      queue_fill = 0;
      next_to_send = 0;
      outstanding = 0;
      generated = 0;
      acked = 0;
      attempt_sum = 0;
      rtt_mean = 0;
      pending_results.delete();
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_WINDOW_LIMIT:    window_limit = v[7:0];
        CFG_SEQ_BITS:        seq_bits = v[3:0];
        CFG_TOTAL_PACKETS:   total_packets = v[15:0];
        CFG_BUFFER_LIMIT:    buffer_limit = v[6:0];
        CFG_INITIAL_TIMEOUT: initial_timeout = v;
        default: ;
      endcase
    endfunction

    function int unsigned eff_window();
      int unsigned sb, w, cap;
      sb = (seq_bits == 0) ? 1 : seq_bits;
      cap = (1 << sb) - 1;
      w = window_limit;
      if (w > cap) w = cap;
      if (w > 255) w = 255;
      if (w < 1) w = 1;
      return w;
    endfunction

    function int unsigned eff_buffer();
      int unsigned b;
      b = (buffer_limit == 0) ? 1 : buffer_limit;
      return (b > 64) ? 64 : b;
    endfunction

    function bit is_late(logic [31:0] age);
      if (acked > 10) return ({24'd0, age, 8'd0}) >= (rtt_mean << 1);
      return age >= initial_timeout;
    endfunction

    function void transmit(int unsigned s, kind_t k, ref arq_res_t r);
      if (attempt_count[s] != 8'hFF) attempt_count[s]++;
      sent_time[s] = now;
      r.kind = k;
      r.seq = 8'(s);
      r.length = sent_length[s];
      r.attempts = attempt_count[s];
    endfunction

    function void note_word(op_t op, logic [7:0] aseq, logic [15:0] len);
      arq_res_t r;
      int unsigned s, best;
      logic [31:0] age, best_age;
      bit found;
      logic [32:0] sum;
      r = '0;
      r.kind = K_NONE;
      case (op)
        OP_TICK: begin
          now++;
          if (outstanding < eff_window() && next_to_send < queue_fill) begin
            s = queue_seq[next_to_send];
            if (attempt_count[s] != 0) begin
              if (is_late(now - sent_time[s])) transmit(s, K_RESENT, r);
            end else begin
              sent_length[s] = queue_length[next_to_send];
              transmit(s, K_SENT, r);
              next_to_send++;
              outstanding++;
            end
          end else begin
            found = 0;
            best = 0;
            best_age = 0;
            for (int i = 0; i < 256; i++) begin
              if (attempt_count[i] != 0) begin
                age = now - sent_time[i];
                if (!found || age > best_age) begin
                  found = 1;
                  best = i;
                  best_age = age;
                end
              end
            end
            if (found && is_late(best_age)) transmit(best, K_RESENT, r);
          end
        end
        OP_NEW: begin
          if (generated >= total_packets || queue_fill >= eff_buffer()) begin
            r.kind = K_DROPPED;
          end else begin
            s = generated % eff_window();
            queue_seq[queue_fill] = 8'(s);
            queue_length[queue_fill] = len;
            queue_fill++;
            generated++;
            r.kind = K_QUEUED;
            r.seq = 8'(s);
          end
        end
        OP_ACK: begin
          s = aseq;
          r.seq = aseq;
          if (attempt_count[s] == 0) begin
            r.kind = K_STRAY;
          end else begin
            age = now - sent_time[s];
            rtt_mean = (rtt_mean * acked + ({32'd0, age} << 8)) / (acked + 1);
            sum = attempt_sum + attempt_count[s];
            attempt_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (acked < 16'hFFFF) acked++;
            for (int i = 0; i < next_to_send && i < queue_fill; i++) begin
              if (queue_seq[i] == s) begin
                for (int j = i; j + 1 < queue_fill; j++) begin
                  queue_seq[j] = queue_seq[j + 1];
                  queue_length[j] = queue_length[j + 1];
                end
                queue_fill--;
                next_to_send--;
                break;
              end
            end
            r.kind = K_ACKED;
            r.attempts = attempt_count[s];
            r.rtt_ticks = age;
            r.attempts_total = attempt_sum;
            attempt_count[s] = 0;
            if (outstanding > 0) outstanding--;
          end
        end
        default: ;
      endcase
      r.done_res = (acked >= total_packets);
      pending_results = {pending_results, r};
    endfunction

    function void check_word(arq_res_t got);
      arq_res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
      end
    endfunction

    function int unsigned outstanding_list(ref int unsigned lst[$]);
      lst.delete();
      for (int i = 0; i < 256; i++) if (attempt_count[i] != 0) lst = {lst, i};
      return lst.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_op = 0;
  logic [7:0]  in_ack_seq = 0;
  logic [15:0] in_pkt_length = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_kind;
  logic [7:0]  out_seq;
  logic [15:0] out_length;
  logic [7:0]  out_attempts;
  logic [31:0] out_rtt_ticks;
  logic [31:0] out_attempts_total;
  logic        out_done_res;
  logic        cfg_we = 0;
  logic [2:0]  cfg_idx = 0;
  logic [31:0] cfg_data = 0;

  arq_scoreboard sb = new();
  bit            sending_done = 0;
  int            stall_cycles = 0;
  bit            timed_out = 0;

  selective_repeat_sender_window u_top (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word({kind_t'(out_kind), out_seq, out_length, out_attempts, out_rtt_ticks,
                     out_attempts_total, out_done_res});
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) stall_cycles++;
    else stall_cycles = 0;
    if (stall_cycles > 20000) timed_out = 1;
  end

  initial begin
    int unsigned gap;
    forever begin
      @(posedge clk);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 7) != 0);
    end
  end

  task automatic send_word(op_t op, logic [7:0] aseq, logic [15:0] len, bit idle_ok);
    int unsigned gap;
    gap = idle_ok ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_ack_seq <= aseq;
    in_pkt_length <= len;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, aseq, len);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_results.size() != 0 && !timed_out) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned lst[$];
    int unsigned k, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) send_word(OP_TICK, 8'($urandom), 16'($urandom), 1);
      else if (pick < 65) send_word(OP_NEW, 8'($urandom), 16'($urandom), 1);
      else if (pick < 93) begin
        k = sb.outstanding_list(lst);
        if (k != 0) send_word(OP_ACK, 8'(lst[$urandom_range(0, k - 1)]), 16'($urandom), 1);
        else send_word(OP_ACK, 8'($urandom), 16'($urandom), 1);
      end else if (pick < 98) send_word(OP_ACK, 8'($urandom), 16'($urandom), 1);
      else send_word(OP_NOP, 8'($urandom), 16'($urandom), 1);
      if (timed_out) return;
    end
  endtask

  initial begin
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_reg(CFG_INITIAL_TIMEOUT, 3);
    send_word(OP_ACK, 8'd0, 16'd0, 0);
    send_word(OP_ACK, 8'hFF, 16'd0, 0);
    send_word(OP_TICK, 8'd0, 16'd0, 0);
    send_word(OP_NEW, 8'd0, 16'hFFFF, 0);
    send_word(OP_NEW, 8'd0, 16'd0, 0);
    send_word(OP_NEW, 8'hFF, 16'h5A5A, 0);
    send_word(OP_TICK, 8'd0, 16'd0, 0);
    send_word(OP_TICK, 8'd0, 16'd0, 0);
    send_word(OP_TICK, 8'd0, 16'd0, 0);
    send_word(OP_TICK, 8'd0, 16'd0, 0);
    send_word(OP_TICK, 8'd0, 16'd0, 0);
    send_word(OP_ACK, 8'd1, 16'd0, 0);
    send_word(OP_ACK, 8'd1, 16'd0, 0);
    send_word(OP_NOP, 8'hFF, 16'hFFFF, 0);
    send_word(OP_ACK, 8'd0, 16'd0, 0);
    send_word(OP_TICK, 8'd0, 16'd0, 0);
    send_word(OP_ACK, 8'd2, 16'd0, 0);
    drain();

    set_reg(CFG_WINDOW_LIMIT, 1);
    set_reg(CFG_SEQ_BITS, 1);
    set_reg(CFG_BUFFER_LIMIT, 1);
    set_reg(CFG_TOTAL_PACKETS, 40);
    set_reg(CFG_INITIAL_TIMEOUT, 2);
    random_phase(300);
    drain();

    set_reg(CFG_WINDOW_LIMIT, 255);
    set_reg(CFG_SEQ_BITS, 8);
    set_reg(CFG_BUFFER_LIMIT, 64);
    set_reg(CFG_TOTAL_PACKETS, 65535);
    set_reg(CFG_INITIAL_TIMEOUT, 32'hFFFF_FFFF);
    random_phase(400);
    drain();

    set_reg(CFG_WINDOW_LIMIT, 200);
    set_reg(CFG_SEQ_BITS, 3);
    set_reg(CFG_BUFFER_LIMIT, 0);
    set_reg(CFG_INITIAL_TIMEOUT, 5);
    random_phase(300);
    drain();

    set_reg(CFG_WINDOW_LIMIT, 12);
    set_reg(CFG_SEQ_BITS, 0);
    set_reg(CFG_BUFFER_LIMIT, 127);
    set_reg(CFG_TOTAL_PACKETS, 1);
    random_phase(150);
    drain();

    set_reg(CFG_WINDOW_LIMIT, 16);
    set_reg(CFG_SEQ_BITS, 15);
    set_reg(CFG_BUFFER_LIMIT, 20);
    set_reg(CFG_TOTAL_PACKETS, 65535);
    set_reg(CFG_INITIAL_TIMEOUT, 8);
    random_phase(850);

    sending_done = 1;
    drain();
    if (timed_out) begin
      $display("SCOREBOARD MISMATCH");
    end else if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    if (!sending_done) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end
endmodule
